// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge once reset has been released
`define ASSERT_CLKD(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tshf_pkg.sv -----
package tshf_pkg;

	localparam int COUNT_BITS_DEFAULT = 16;
	localparam int CFG_W = 15;

	// button flag codes
	localparam logic [7:0] FLAG_IGNITION = 8'h80;
	localparam logic [7:0] FLAG_HAZARD   = 8'h40;
	localparam logic [7:0] FLAG_RIGHT    = 8'h01;
	localparam logic [7:0] FLAG_LEFT     = 8'h02;
	localparam logic [7:0] FLAG_BOTH     = 8'h04;

	// port levels that count as a held turn button
	localparam logic [7:0] PORT_HELD_MIN = 8'h01;
	localparam logic [7:0] PORT_HELD_MAX = 8'h04;

	localparam logic [1:0] TURN_NONE  = 2'd0;
	localparam logic [1:0] TURN_RIGHT = 2'd1;
	localparam logic [1:0] TURN_LEFT  = 2'd2;
	localparam logic [1:0] TURN_BOTH  = 2'd3;

	localparam logic [1:0] OFF_PHASE_LIMIT = 2'd3;

	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_BUTTON = 1'b1;

	// lamp bit positions
	localparam int LAMP_RIGHT = 0;
	localparam int LAMP_LEFT  = 1;
	localparam int LAMP_IGN   = 2;

	// register index, taken from paddr[2]
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_OFF    = 1'b1;

	localparam logic [CFG_W-1:0] PERIOD_RESET = 15'd20;
	localparam logic [CFG_W-1:0] OFF_RESET    = 15'd10;

	typedef struct packed {
		logic [CFG_W-1:0] period_ticks;
		logic [CFG_W-1:0] off_tick;
	} cfg_t;

	// packed so that right_lamp lands in bit 0
	typedef struct packed {
		logic [1:0] direction;
		logic       hazard_on;
		logic       timer_on;
		logic       ignition_lamp;
		logic       left_lamp;
		logic       right_lamp;
	} result_t;

endpackage

// ----- design/tshf_cfg.sv -----
module tshf_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output tshf_pkg::cfg_t       cfg
);
	import tshf_pkg::*;

	logic [CFG_W-1:0] period_q;
	logic [CFG_W-1:0] off_q;
	logic             wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			off_q    <= OFF_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_PERIOD: period_q <= pwdata[CFG_W-1:0];
				REG_OFF:    off_q    <= pwdata[CFG_W-1:0];
				default:    period_q <= period_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_PERIOD: prdata[CFG_W-1:0] = period_q;
			REG_OFF:    prdata[CFG_W-1:0] = off_q;
			default:    prdata = '0;
		endcase
	end

	assign cfg.period_ticks = period_q;
	assign cfg.off_tick     = off_q;

endmodule

// ----- design/tshf_core.sv -----
module tshf_core #(
	parameter int COUNT_BITS = tshf_pkg::COUNT_BITS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              mode,
	input  logic [7:0]        irq_flags,
	input  logic [7:0]        port_level,
	input  tshf_pkg::cfg_t    cfg,
	output tshf_pkg::result_t result
);
	import tshf_pkg::*;

	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic                  ign_q, ign_d;
	logic                  haz_q, haz_d;
	logic [1:0]            turn_q, turn_d;
	logic [1:0]            phase_q, phase_d;
	logic                  timer_q, timer_d;
	logic [2:0]            lamps_q, lamps_d;

	logic [COUNT_BITS-1:0] offv;
	logic [COUNT_BITS-1:0] reload;
	logic                  held;

	// register values are compared as patterns cut or widened to the counter width
	assign offv   = COUNT_BITS'(cfg.off_tick);
	assign reload = COUNT_BITS'(cfg.period_ticks);
	assign held   = (port_level >= PORT_HELD_MIN) && (port_level <= PORT_HELD_MAX);

	always_comb begin
		cnt_d   = cnt_q;
		ign_d   = ign_q;
		haz_d   = haz_q;
		turn_d  = turn_q;
		phase_d = phase_q;
		timer_d = timer_q;
		lamps_d = lamps_q;
		if (mode == MODE_TICK) begin
			if (timer_q) begin
				cnt_d = cnt_q - 1'b1;
				if (haz_q && turn_q == TURN_NONE) begin
					if (cnt_d == offv) begin
						lamps_d[LAMP_RIGHT] = 1'b0;
						lamps_d[LAMP_LEFT]  = 1'b0;
					end
					if (cnt_d == '0) begin
						lamps_d[LAMP_RIGHT] = 1'b1;
						lamps_d[LAMP_LEFT]  = 1'b1;
						cnt_d = reload;
					end
				end
				if (!haz_q) begin
					if (cnt_d == offv) begin
						lamps_d[LAMP_RIGHT] = 1'b0;
						lamps_d[LAMP_LEFT]  = 1'b0;
						phase_d = phase_q + 2'd1;
						if (phase_d == OFF_PHASE_LIMIT) begin
							if (held) begin
								phase_d = 2'd1;
							end else begin
								timer_d = 1'b0;
								phase_d = 2'd0;
								turn_d  = TURN_NONE;
							end
						end
					end
					// off and on at the same count: the on action wins, seeing the new turn
					if (cnt_d == '0 && ign_q) begin
						unique case (turn_d)
							TURN_RIGHT: begin
								lamps_d[LAMP_LEFT]  = 1'b0;
								lamps_d[LAMP_RIGHT] = 1'b1;
							end
							TURN_LEFT: begin
								lamps_d[LAMP_RIGHT] = 1'b0;
								lamps_d[LAMP_LEFT]  = 1'b1;
							end
							TURN_BOTH: begin
								lamps_d[LAMP_RIGHT] = 1'b1;
								lamps_d[LAMP_LEFT]  = 1'b1;
							end
							default: lamps_d = lamps_d;
						endcase
						cnt_d = reload;
					end
				end
			end
		end else begin
			unique case (irq_flags)
				FLAG_IGNITION: begin
					if (!ign_q) begin
						ign_d = 1'b1;
						lamps_d[LAMP_IGN] = 1'b1;
					end else begin
						ign_d   = 1'b0;
						lamps_d = '0;
					end
				end
				FLAG_HAZARD: begin
					if (haz_q) begin
						haz_d = 1'b0;
						lamps_d[LAMP_RIGHT] = 1'b0;
						lamps_d[LAMP_LEFT]  = 1'b0;
						timer_d = 1'b0;
					end else if (turn_q == TURN_NONE) begin
						haz_d   = 1'b1;
						cnt_d   = COUNT_BITS'(1);
						timer_d = 1'b1;
					end
				end
				FLAG_RIGHT, FLAG_LEFT, FLAG_BOTH: begin
					if (ign_q) begin
						cnt_d   = COUNT_BITS'(1);
						haz_d   = 1'b0;
						phase_d = 2'd0;
						timer_d = 1'b1;
						if (irq_flags == FLAG_RIGHT) begin
							turn_d = TURN_RIGHT;
						end else if (irq_flags == FLAG_LEFT) begin
							turn_d = TURN_LEFT;
						end else begin
							turn_d = TURN_BOTH;
						end
					end
				end
				default: ign_d = ign_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ign_q   <= 1'b0;
			haz_q   <= 1'b0;
			turn_q  <= TURN_NONE;
			phase_q <= 2'd0;
			timer_q <= 1'b0;
			lamps_q <= '0;
		end else if (step) begin
			cnt_q   <= cnt_d;
			ign_q   <= ign_d;
			haz_q   <= haz_d;
			turn_q  <= turn_d;
			phase_q <= phase_d;
			timer_q <= timer_d;
			lamps_q <= lamps_d;
		end
	end

	assign result.right_lamp    = lamps_d[LAMP_RIGHT];
	assign result.left_lamp     = lamps_d[LAMP_LEFT];
	assign result.ignition_lamp = lamps_d[LAMP_IGN];
	assign result.timer_on      = timer_d;
	assign result.hazard_on     = haz_d;
	assign result.direction     = turn_d;

endmodule

// ----- design/turn_signal_hazard_flasher.sv -----
// channel   dir  tdata                          tuser / other
// s_axis    in   irq_flags[7:0], port_level[15:8]  tuser: mode (0 tick, 1 button)
// m_axis    out  right, left, ignition, timer_on, hazard_on, direction[6:5]
// apb       in   period_ticks at 0x0, off_tick at 0x4 (15 bits each)
//
// one transfer per cycle in each direction while the result side does not stall; an item passes
// the input register, then state update and result register in the same cycle
// reset clears state, config returns to period 20, off tick 10
// a stalled result holds the result register; the input register still takes one more item
`include "assert_macros.svh"

module turn_signal_hazard_flasher #(
	parameter int COUNT_BITS = tshf_pkg::COUNT_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // irq_flags[7:0], port_level[15:8]
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // right_lamp, left_lamp, ignition_lamp, timer_on,
	                               // hazard_on, direction[6:5], zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tshf_pkg::*;

	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] flags_s1;
	logic [7:0] port_s1;
	logic       advance;
	logic       step;
	logic       out_valid_q;
	result_t    res_q;
	result_t    result;
	cfg_t       cfg;

	assign pready   = 1'b1;
	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1  <= s_tuser;
			flags_s1 <= s_tdata[7:0];
			port_s1  <= s_tdata[15:8];
		end
	end

	tshf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tshf_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.mode       (mode_s1),
		.irq_flags  (flags_s1),
		.port_level (port_s1),
		.cfg        (cfg),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q};

	// hazard and a turn selection never hold together
	`ASSERT_CLKD(a_hazard_no_turn, m_tvalid |-> (!res_q.hazard_on || res_q.direction == TURN_NONE), "hazard with turn selected")
	// the input side only stalls behind a full, blocked result register
	`ASSERT_CLKD(a_stall_cause, !s_tready |-> (m_tvalid && !m_tready && valid_s1), "input stalled without cause")
	// an accepted item is held in the input register on the next cycle
	`ASSERT_CLKD(a_accept_loads, (s_tvalid && s_tready) |=> valid_s1, "accepted item lost")
	// no result is shown while reset is held
	`ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule

// ----- sim/turn_signal_hazard_flasher_test.sv -----
`timescale 1ns / 100ps

module turn_signal_hazard_flasher_test;
	import tshf_pkg::*;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int PHASE_ITEMS    = 145;
	localparam int PRINT_LIMIT    = 20;
	localparam logic [7:0] PORT_IDLE = 8'h00;

	typedef struct packed {
		logic       mode;
		logic [7:0] flags;
		logic [7:0] port;
	} flasher_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // irq_flags[7:0], port_level[15:8]
	logic        s_tuser = 1'b0; // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // right, left, ignition, timer_on, hazard_on, direction[6:5]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	turn_signal_hazard_flasher dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// flasher state as the block should hold it
	logic [CFG_W-1:0] period_cfg = PERIOD_RESET;
	logic [CFG_W-1:0] off_cfg    = OFF_RESET;
	logic [COUNT_BITS_DEFAULT-1:0] blink_count = '0;
	logic        ignition    = 1'b0;
	logic        hazard      = 1'b0;
	logic [1:0]  turn        = TURN_NONE;
	logic [1:0]  off_phases  = '0;
	logic        timer_run   = 1'b0;
	logic [2:0]  lamps       = '0;

	result_t       lamp_status_q[$];
	flasher_item_t outbox[$];

	int  mismatches = 0;
	int  items_sent = 0;
	int  busy_items = 0;
	int  results_seen = 0;
	int  settings_used = 1;
	int  cycles = 0;
	int  send_hold = 0;
	int  stall_left = 0;
	bit  no_gaps = 1'b0;

	function automatic result_t advance_flasher(input logic mode, input logic [7:0] flags,
			input logic [7:0] port);
		result_t r;
		if (mode == MODE_TICK) begin
			if (timer_run) begin
				blink_count = blink_count - 1'b1;
				if (hazard && turn == TURN_NONE) begin
					if (blink_count == COUNT_BITS_DEFAULT'(off_cfg)) begin
						lamps[LAMP_RIGHT] = 1'b0;
						lamps[LAMP_LEFT]  = 1'b0;
					end
					if (blink_count == '0) begin
						lamps[LAMP_RIGHT] = 1'b1;
						lamps[LAMP_LEFT]  = 1'b1;
						blink_count = COUNT_BITS_DEFAULT'(period_cfg);
					end
				end
				if (!hazard) begin
					if (blink_count == COUNT_BITS_DEFAULT'(off_cfg)) begin
						lamps[LAMP_RIGHT] = 1'b0;
						lamps[LAMP_LEFT]  = 1'b0;
						off_phases = off_phases + 2'd1;
						if (off_phases == OFF_PHASE_LIMIT) begin
							// a held turn button keeps the indicator going
							if (port >= PORT_HELD_MIN && port <= PORT_HELD_MAX) begin
								off_phases = 2'd1;
							end else begin
								timer_run  = 1'b0;
								off_phases = '0;
								turn       = TURN_NONE;
							end
						end
					end
					if (blink_count == '0 && ignition) begin
						case (turn)
							TURN_RIGHT: begin
								lamps[LAMP_LEFT]  = 1'b0;
								lamps[LAMP_RIGHT] = 1'b1;
							end
							TURN_LEFT: begin
								lamps[LAMP_RIGHT] = 1'b0;
								lamps[LAMP_LEFT]  = 1'b1;
							end
							TURN_BOTH: begin
								lamps[LAMP_RIGHT] = 1'b1;
								lamps[LAMP_LEFT]  = 1'b1;
							end
							default: ;
						endcase
						blink_count = COUNT_BITS_DEFAULT'(period_cfg);
					end
				end
			end
		end else begin
			case (flags)
				FLAG_IGNITION: begin
					if (!ignition) begin
						ignition = 1'b1;
						lamps[LAMP_IGN] = 1'b1;
					end else begin
						ignition = 1'b0;
						lamps = '0;
					end
				end
				FLAG_HAZARD: begin
					if (hazard) begin
						hazard = 1'b0;
						lamps[LAMP_RIGHT] = 1'b0;
						lamps[LAMP_LEFT]  = 1'b0;
						timer_run = 1'b0;
					end else if (turn == TURN_NONE) begin
						hazard = 1'b1;
						blink_count = COUNT_BITS_DEFAULT'(1);
						timer_run = 1'b1;
					end
				end
				FLAG_RIGHT, FLAG_LEFT, FLAG_BOTH: begin
					if (ignition) begin
						blink_count = COUNT_BITS_DEFAULT'(1);
						hazard = 1'b0;
						turn = (flags == FLAG_RIGHT) ? TURN_RIGHT :
							(flags == FLAG_LEFT) ? TURN_LEFT : TURN_BOTH;
						off_phases = '0;
						timer_run = 1'b1;
					end
				end
				default: ;
			endcase
		end
		r.right_lamp    = lamps[LAMP_RIGHT];
		r.left_lamp     = lamps[LAMP_LEFT];
		r.ignition_lamp = lamps[LAMP_IGN];
		r.timer_on      = timer_run;
		r.hazard_on     = hazard;
		r.direction     = turn;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 4))
			0: return FLAG_IGNITION;
			1: return FLAG_HAZARD;
			2: return FLAG_RIGHT;
			3: return FLAG_LEFT;
			default: return FLAG_BOTH;
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_port();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(PORT_HELD_MIN, PORT_HELD_MAX));
		return pick_byte();
	endfunction

	// enough ticks for three blink periods, kept short when the period is long
	function automatic int tick_span();
		return (period_cfg <= 12) ? 4 * (period_cfg + 1) + 4 : 60;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at result %0d: %s got %0d, expected %0d",
				results_seen, what, got, want);
	endtask

	task automatic send_item(input logic mode, input logic [7:0] flags,
			input logic [7:0] port);
		flasher_item_t it;
		it.mode  = mode;
		it.flags = flags;
		it.port  = port;
		if (!(mode == MODE_TICK && !timer_run))
			busy_items++;
		items_sent++;
		lamp_status_q.push_back(advance_flasher(mode, flags, port));
		outbox.push_back(it);
		while (outbox.size() > 1)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		while (outbox.size() != 0 || lamp_status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic read_check(input logic idx, input logic [CFG_W-1:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {17'd0, want})
			report_mismatch(idx == REG_PERIOD ? "period_ticks readback" : "off_tick readback",
				prdata, want);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {17'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_PERIOD)
			period_cfg = value;
		else
			off_cfg = value;
		read_check(idx, value);
	endtask

	task automatic set_blink(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] off);
		wait_drained();
		write_reg(REG_PERIOD, period);
		write_reg(REG_OFF, off);
		settings_used++;
	endtask

	task automatic turn_sequence();
		int n;
		if (!ignition)
			send_item(MODE_BUTTON, FLAG_IGNITION, pick_byte());
		case ($urandom_range(0, 2))
			0: send_item(MODE_BUTTON, FLAG_RIGHT, pick_byte());
			1: send_item(MODE_BUTTON, FLAG_LEFT, pick_byte());
			default: send_item(MODE_BUTTON, FLAG_BOTH, pick_byte());
		endcase
		n = $urandom_range(1, tick_span());
		repeat (n) begin
			if ($urandom_range(0, 19) == 0)
				send_item(MODE_BUTTON, $urandom_range(0, 1) ? pick_code() : pick_byte(),
					pick_byte());
			else
				send_item(MODE_TICK, pick_byte(), pick_port());
		end
	endtask

	task automatic hazard_sequence();
		int n;
		// a running turn signal blocks hazard, so let it run out first
		if (turn != TURN_NONE && off_cfg < period_cfg && period_cfg <= 64) begin
			if (!ignition)
				send_item(MODE_BUTTON, FLAG_IGNITION, pick_byte());
			for (int i = 0; i < tick_span() && turn != TURN_NONE; i++)
				send_item(MODE_TICK, pick_byte(), PORT_IDLE);
		end
		send_item(MODE_BUTTON, FLAG_HAZARD, pick_byte());
		n = $urandom_range(1, tick_span());
		repeat (n)
			send_item(MODE_TICK, pick_byte(), pick_byte());
		if ($urandom_range(0, 1))
			send_item(MODE_BUTTON, FLAG_HAZARD, pick_byte());
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(3, 10))
			send_item(1'($urandom_range(0, 1)),
				$urandom_range(0, 1) ? pick_code() : pick_byte(),
				pick_byte());
	endtask

	task automatic test_register_reset();
		read_check(REG_PERIOD, PERIOD_RESET);
		read_check(REG_OFF, OFF_RESET);
	endtask

	// stopped ticks, unknown flag bytes, hazard on and off, ignition toggling
	task automatic test_idle_items();
		send_item(MODE_TICK, 8'hFF, 8'hFF);
		send_item(MODE_BUTTON, 8'h00, 8'h00);
		send_item(MODE_BUTTON, 8'hFF, 8'hAA);
		send_item(MODE_BUTTON, FLAG_RIGHT | FLAG_LEFT, 8'h55);
		send_item(MODE_BUTTON, 8'h20, 8'h00);
		send_item(MODE_BUTTON, FLAG_RIGHT, 8'h00);
		send_item(MODE_BUTTON, FLAG_HAZARD, 8'h00);
		send_item(MODE_TICK, 8'h00, 8'h00);
		send_item(MODE_BUTTON, FLAG_LEFT, 8'h00);
		send_item(MODE_BUTTON, FLAG_HAZARD, 8'h00);
		send_item(MODE_BUTTON, FLAG_IGNITION, 8'h00);
		send_item(MODE_BUTTON, FLAG_IGNITION, 8'h00);
	endtask

	// shortest period: held button restarts the phase count, then the signal runs out
	task automatic test_turn_stop();
		set_blink(15'd2, 15'd1);
		send_item(MODE_BUTTON, FLAG_IGNITION, 8'h00);
		send_item(MODE_BUTTON, FLAG_BOTH, 8'h00);
		repeat (6) send_item(MODE_TICK, 8'h00, PORT_HELD_MAX);
		send_item(MODE_BUTTON, FLAG_HAZARD, 8'h00);
		repeat (4) send_item(MODE_TICK, 8'h00, 8'h05);
	endtask

	task automatic test_random_phases();
		logic [CFG_W-1:0] periods[8] = '{15'd20, 15'd32767, 15'd5, 15'd3, 15'd2,
			15'd0, 15'd0, 15'd0};
		logic [CFG_W-1:0] offs[8]    = '{15'd10, 15'd32766, 15'd0, 15'd9, 15'd1,
			15'd0, 15'd0, 15'd0};
		int goal;
		int r;
		for (int p = 5; p < 8; p++) begin
			periods[p] = CFG_W'($urandom_range(2, 12));
			offs[p]    = CFG_W'($urandom_range(0, periods[p] + 2));
		end
		for (int p = 0; p < 8; p++) begin
			set_blink(periods[p], offs[p]);
			no_gaps = ($urandom_range(0, 3) == 0);
			goal = busy_items + PHASE_ITEMS;
			while (busy_items < goal) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					turn_sequence();
				else if (r < 80)
					hazard_sequence();
				else
					noise_burst();
			end
		end
		no_gaps = 1'b0;
	endtask

	// input side: presents queued items, with a random hold-off after each transfer
	always @(posedge clk) begin
		if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid)
				outbox.delete(0);
			if (outbox.size() > 0 && send_hold == 0) begin
				s_tvalid <= 1'b1;
				s_tuser  <= outbox[0].mode;
				s_tdata  <= {outbox[0].port, outbox[0].flags};
				send_hold = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
				if (send_hold > 0)
					send_hold--;
			end
		end
	end

	// output side: compares each result transfer and stalls at random
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[6:0]);
			if (lamp_status_q.size() == 0) begin
				report_mismatch("result with nothing outstanding", m_tdata, 0);
			end else begin
				want = lamp_status_q.pop_front();
				if (got.right_lamp !== want.right_lamp)
					report_mismatch("right_lamp", got.right_lamp, want.right_lamp);
				if (got.left_lamp !== want.left_lamp)
					report_mismatch("left_lamp", got.left_lamp, want.left_lamp);
				if (got.ignition_lamp !== want.ignition_lamp)
					report_mismatch("ignition_lamp", got.ignition_lamp, want.ignition_lamp);
				if (got.timer_on !== want.timer_on)
					report_mismatch("timer_on", got.timer_on, want.timer_on);
				if (got.hazard_on !== want.hazard_on)
					report_mismatch("hazard_on", got.hazard_on, want.hazard_on);
				if (got.direction !== want.direction)
					report_mismatch("direction", got.direction, want.direction);
			end
			results_seen++;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			stall_left = pick_gap();
			m_tready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d items unsent and %0d results outstanding",
				outbox.size(), lamp_status_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_idle_items();
		test_turn_stop();
		test_random_phases();
		wait_drained();
		repeat (10) @(posedge clk);
		$display("%0d items sent (%0d with the timer running or as buttons), %0d results checked",
			items_sent, busy_items, results_seen);
		$display("%0d blink settings used, %0d mismatches", settings_used, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
